FILE: design/ntzk_pkg.sv
// Package for the nearest-to-zero top-k selector.
// Holds the store depth, shared types and the magnitude function.
// No dependencies.
package ntzk_pkg;

  localparam int KEEP_COUNT = 10;
  localparam int CNT_W = $clog2(KEEP_COUNT + 1);

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_ROTATE
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_REPORT
  } state_e;

  typedef struct packed {
    logic        valid;
    logic [30:0] key;
    logic [31:0] energy;
    logic [31:0] linewidth;
  } entry_t;

  typedef struct packed {
    cell_op_e    op;
    logic [30:0] key;
    logic [31:0] energy;
    logic [31:0] linewidth;
  } cell_ctrl_t;

  // |e| clipped to 31 bits; the most negative value saturates
  function automatic logic [30:0] magnitude31(logic [31:0] e);
    logic [31:0] neg;
    neg = ~e + 32'd1;
    if (!e[31]) begin
      return e[30:0];
    end else if (neg[31]) begin
      return 31'h7FFF_FFFF;
    end else begin
      return neg[30:0];
    end
  endfunction

endpackage

FILE: design/ntzk_cell.sv
// One slot of the sorted store: holds a key, energy and linewidth.
// Inserts by compare-and-shift from its lower neighbor, rotates from its upper one.
// Depends on ntzk_pkg.
module ntzk_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ntzk_pkg::cell_ctrl_t ctrl_i,
  input  ntzk_pkg::entry_t    prev_i,
  input  logic                prev_take_i,
  input  ntzk_pkg::entry_t    next_i,
  output ntzk_pkg::entry_t    entry_o,
  output logic                take_o
);
  import ntzk_pkg::*;

  logic        valid_q, valid_d;
  logic [30:0] key_q, key_d;
  logic [31:0] energy_q, energy_d;
  logic [31:0] linewidth_q, linewidth_d;

  // this slot yields to the new item: empty or strictly larger key
  assign take_o = !valid_q || (key_q > ctrl_i.key);

  always_comb begin
    valid_d     = valid_q;
    key_d       = key_q;
    energy_d    = energy_q;
    linewidth_d = linewidth_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (take_o) begin
          if (prev_take_i) begin
            valid_d     = prev_i.valid;
            key_d       = prev_i.key;
            energy_d    = prev_i.energy;
            linewidth_d = prev_i.linewidth;
          end else begin
            valid_d     = 1'b1;
            key_d       = ctrl_i.key;
            energy_d    = ctrl_i.energy;
            linewidth_d = ctrl_i.linewidth;
          end
        end
      end
      OP_ROTATE: begin
        valid_d     = next_i.valid;
        key_d       = next_i.key;
        energy_d    = next_i.energy;
        linewidth_d = next_i.linewidth;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    energy_q    <= energy_d;
    linewidth_q <= linewidth_d;
  end

  assign entry_o = '{valid: valid_q, key: key_q, energy: energy_q, linewidth: linewidth_q};

endmodule

FILE: design/nearest_to_zero_top_k.sv
// Top level of the nearest-to-zero top-k selector: control, fill count and
// a row of ntzk_cell slots. Depends on ntzk_pkg and ntzk_cell.
//
// Usage:
//   Command channel: an item transfers at a rising edge with start_i high and
//   busy_o low. cmd_i = 0 adds (energy_i, linewidth_i); cmd_i = 1 reports.
//   An add is absorbed by a parallel compare-and-shift over the row of
//   cells; busy_o stays low, so one add per cycle is sustained.
//   A report rotates the row once around with busy_o high,
//   and presents held entries in ascending |energy| order from cell 0.
//   Entries are shown in that order, one per cycle,
//   with out_strobe_o high for exactly one cycle each; last_entry_o marks the
//   final one. An empty store reports nothing but still stays busy for
//   the whole rotation. Results cannot be stalled: the receiver must take
//   each one in the cycle it is shown.
//   Reset empties the store and returns to idle; no clearing pass is needed.
module nearest_to_zero_top_k (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cmd_i,
  input  logic signed [31:0] energy_i,
  input  logic [31:0] linewidth_i,
  output logic        out_strobe_o,
  output logic signed [31:0] out_energy_o,
  output logic [31:0] out_linewidth_o,
  output logic        last_entry_o
);
  import ntzk_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] step_q, step_d;
  logic             strobe_q, strobe_d;
  logic             last_q, last_d;
  logic [31:0]      energy_q;
  logic [31:0]      linewidth_q;

  cell_ctrl_t ctrl;
  entry_t     entry_w [KEEP_COUNT];
  logic       take_w  [KEEP_COUNT];
  logic       add_go;

  assign add_go = (state_q == ST_IDLE) && start_i && !cmd_i;

  always_comb begin
    ctrl.key       = magnitude31(energy_i);
    ctrl.energy    = energy_i;
    ctrl.linewidth = linewidth_i;
    if (add_go) begin
      ctrl.op = OP_INSERT;
    end else if (state_q == ST_REPORT) begin
      ctrl.op = OP_ROTATE;
    end else begin
      ctrl.op = OP_HOLD;
    end
  end

  for (genvar i = 0; i < KEEP_COUNT; i++) begin : g_cell
    entry_t prev_w;
    entry_t next_w;
    logic   prev_take_w;
    if (i == 0) begin : g_first
      assign prev_w      = '0;
      assign prev_take_w = 1'b0;
    end else begin : g_mid
      assign prev_w      = entry_w[i-1];
      assign prev_take_w = take_w[i-1];
    end
    if (i == KEEP_COUNT - 1) begin : g_wrap
      assign next_w = entry_w[0];
    end else begin : g_next
      assign next_w = entry_w[i+1];
    end
    ntzk_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .prev_i     (prev_w),
      .prev_take_i(prev_take_w),
      .next_i     (next_w),
      .entry_o    (entry_w[i]),
      .take_o     (take_w[i])
    );
  end

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    step_d   = step_q;
    strobe_d = 1'b0;
    last_d   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (start_i) begin
          if (cmd_i) begin
            state_d = ST_REPORT;
          end else if (fill_q != CNT_W'(KEEP_COUNT)) begin
            fill_d = fill_q + CNT_W'(1);
          end
        end
      end
      ST_REPORT: begin
        strobe_d = step_q < fill_q;
        last_d   = (CNT_W'(step_q + CNT_W'(1)) == fill_q);
        step_d   = step_q + CNT_W'(1);
        if (step_q == CNT_W'(KEEP_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      step_q   <= '0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      step_q   <= step_d;
      strobe_q <= strobe_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    energy_q    <= entry_w[0].energy;
    linewidth_q <= entry_w[0].linewidth;
  end

  assign busy_o          = (state_q == ST_REPORT);
  assign out_strobe_o    = strobe_q;
  assign out_energy_o    = signed'(energy_q);
  assign out_linewidth_o = linewidth_q;
  assign last_entry_o    = strobe_q && last_q;

endmodule

FILE: design/ntzk_checker.sv
// Port-level checks for nearest_to_zero_top_k, bound to the top level.
// Depends on nearest_to_zero_top_k port names.
module ntzk_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        cmd_i,
  input logic        out_strobe_o,
  input logic        last_entry_o
);

  // last flag only on a strobed transfer
  a_last_strobed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_entry_o |-> out_strobe_o)
    else $error("last_entry_o without out_strobe_o");

  // an add transfer never yields a result
  a_add_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !cmd_i) |=> !out_strobe_o)
    else $error("result after add transfer");

  // a report transfer occupies the block
  a_report_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cmd_i) |=> busy_o)
    else $error("not busy after report transfer");

  // results of one report come back to back until the last one
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && !last_entry_o) |=> out_strobe_o)
    else $error("gap in report burst");

endmodule

bind nearest_to_zero_top_k ntzk_checker u_ntzk_checker (.*);

FILE: verif/testbench.sv
// Testbench for nearest_to_zero_top_k: directed table, then random add/report traffic.
// Results are checked against an in-bench model of the sorted store.
// Depends on ntzk_pkg and the design sources.
module testbench;

  import ntzk_pkg::*;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REPORT = 1'b1;
  localparam int   DIRECTED_N = 22;
  localparam int   RANDOM_N   = 250;

  typedef struct packed {
    logic        cmd;
    logic [31:0] energy;
    logic [31:0] linewidth;
    logic        typed;
    logic [3:0]  typed_count;
    logic [31:0] want_energy;
    logic [31:0] want_linewidth;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] energy;
    logic [31:0] linewidth;
    logic        last;
  } held_entry_t;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  logic cmd_i;
  logic signed [31:0] energy_i;
  logic [31:0] linewidth_i;
  logic out_strobe_o;
  logic signed [31:0] out_energy_o;
  logic [31:0] out_linewidth_o;
  logic last_entry_o;

  logic [30:0] store_key [KEEP_COUNT];
  logic [31:0] store_energy [KEEP_COUNT];
  logic [31:0] store_linewidth [KEEP_COUNT];
  int          store_fill;

  held_entry_t pending_entries [$];
  held_entry_t arrived;
  int          error_count;

  // directed stimulus; typed rows carry their expected report by hand
  stim_row_t directed_rows [DIRECTED_N] = '{
    '{CMD_REPORT, 32'h0000_0000, 32'h0000_0000, 1'b1, 4'd0, 32'h0, 32'h0},
    '{CMD_ADD,    32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 4'd0, 32'h0, 32'h0},
    '{CMD_REPORT, 32'h0000_0000, 32'h0000_0000, 1'b1, 4'd1, 32'h8000_0000, 32'hFFFF_FFFF},
    '{CMD_ADD,    32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 4'd0, 32'h0, 32'h0},
    '{CMD_ADD,    32'h0000_0000, 32'h1234_5678, 1'b0, 4'd0, 32'h0, 32'h0},
    '{CMD_ADD,    32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 4'd0, 32'h0, 32'h0},
    '{CMD_ADD,    32'h0000_0001, 32'h0000_0002, 1'b0, 4'd0, 32'h0, 32'h0},
    '{CMD_ADD,    32'hC000_0000, 32'hA5A5_A5A5, 1'b0, 4'd0, 32'h0, 32'h0},
    '{CMD_ADD,    32'h4000_0000, 32'h5A5A_5A5A, 1'b0, 4'd0, 32'h0, 32'h0},
    '{CMD_ADD,    32'h0000_0005, 32'h0000_FFFF, 1'b0, 4'd0, 32'h0, 32'h0},
    '{CMD_ADD,    32'hFFFF_FFFB, 32'hFFFF_0000, 1'b0, 4'd0, 32'h0, 32'h0},
    '{CMD_ADD,    32'h1000_0000, 32'h8000_0000, 1'b0, 4'd0, 32'h0, 32'h0},
    '{CMD_REPORT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 4'd0, 32'h0, 32'h0},
    '{CMD_ADD,    32'h7FFF_FFFF, 32'h1357_9BDF, 1'b0, 4'd0, 32'h0, 32'h0},
    '{CMD_ADD,    32'h8000_0000, 32'h2468_ACE0, 1'b0, 4'd0, 32'h0, 32'h0},
    '{CMD_ADD,    32'h0000_0003, 32'h0F0F_0F0F, 1'b0, 4'd0, 32'h0, 32'h0},
    '{CMD_ADD,    32'hFFFF_FFFD, 32'hF0F0_F0F0, 1'b0, 4'd0, 32'h0, 32'h0},
    '{CMD_REPORT, 32'h0000_0000, 32'h0000_0000, 1'b0, 4'd0, 32'h0, 32'h0},
    '{CMD_ADD,    32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 4'd0, 32'h0, 32'h0},
    '{CMD_REPORT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 4'd0, 32'h0, 32'h0},
    '{CMD_ADD,    32'h7FFF_FFFE, 32'h1111_1111, 1'b0, 4'd0, 32'h0, 32'h0},
    '{CMD_REPORT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 4'd0, 32'h0, 32'h0}
  };

  nearest_to_zero_top_k u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .energy_i       (energy_i),
    .linewidth_i    (linewidth_i),
    .out_strobe_o   (out_strobe_o),
    .out_energy_o   (out_energy_o),
    .out_linewidth_o(out_linewidth_o),
    .last_entry_o   (last_entry_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // appends one expected result at the tail of the pending list
  task automatic expect_entry(input held_entry_t h);
    pending_entries = {pending_entries, h};
  endtask

  // |e| on 31 bits, most negative value clipped to the top
  function automatic logic [30:0] energy_key(input logic [31:0] e);
    logic [31:0] abs_val;
    abs_val = e[31] ? (~e + 32'd1) : e;
    return abs_val[31] ? 31'h7FFF_FFFF : abs_val[30:0];
  endfunction

  task automatic place_entry(input logic [30:0] key, input logic [31:0] e,
                             input logic [31:0] lw);
    int pos;
    pos = 0;
    while (pos < store_fill && store_key[pos] <= key) pos++;
    for (int i = store_fill; i > pos; i--) begin
      store_key[i]       = store_key[i-1];
      store_energy[i]    = store_energy[i-1];
      store_linewidth[i] = store_linewidth[i-1];
    end
    store_key[pos]       = key;
    store_energy[pos]    = e;
    store_linewidth[pos] = lw;
    store_fill++;
  endtask

  // updates the store and queues the report contents when asked
  task automatic apply_command(input logic cmd, input logic [31:0] e,
                               input logic [31:0] lw, input bit queue_report);
    logic [30:0] key;
    held_entry_t h;
    key = energy_key(e);
    if (cmd == CMD_ADD) begin
      if (store_fill < KEEP_COUNT) begin
        place_entry(key, e, lw);
      end else if (key < store_key[KEEP_COUNT-1]) begin
        store_fill = KEEP_COUNT - 1;
        place_entry(key, e, lw);
      end
    end else if (queue_report) begin
      for (int i = 0; i < store_fill; i++) begin
        h.energy    = store_energy[i];
        h.linewidth = store_linewidth[i];
        h.last      = (i == store_fill - 1);
        expect_entry(h);
      end
    end
  endtask

  function automatic logic [31:0] pick_energy();
    logic [31:0] v;
    int idx;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 64);
      2: v = -$urandom_range(0, 64);
      3: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          3: v = 32'h0000_0001;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      4: begin
        if (store_fill > 0) begin
          idx = $urandom_range(0, store_fill - 1);
          v = $urandom_range(0, 1) ? store_energy[idx] : -store_energy[idx];
        end else begin
          v = $urandom;
        end
      end
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // one command transfer; returns in the step of the accepting edge
  task automatic drive_item(input logic cmd, input logic [31:0] e, input logic [31:0] lw,
                            input bit allow_idle);
    if (allow_idle && $urandom_range(0, 99) < 11) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i     <= 1'b1;
    cmd_i       <= cmd;
    energy_i    <= e;
    linewidth_i <= lw;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    start_i <= 1'b0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (pending_entries.size() != 0 && guard < 200);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_strobe_o) begin
      if (pending_entries.size() == 0) begin
        report_mismatch($sformatf("unexpected result energy %h", out_energy_o));
      end else begin
        arrived = pending_entries.pop_front();
        if (out_energy_o !== arrived.energy)
          report_mismatch($sformatf("energy %h, want %h", out_energy_o, arrived.energy));
        if (out_linewidth_o !== arrived.linewidth)
          report_mismatch($sformatf("linewidth %h, want %h", out_linewidth_o,
                                    arrived.linewidth));
        if (last_entry_o !== arrived.last)
          report_mismatch($sformatf("last flag %b, want %b", last_entry_o, arrived.last));
      end
    end
  end

  initial begin
    stim_row_t   row;
    held_entry_t h;
    logic        cmd;
    logic [31:0] e;
    logic [31:0] lw;
    error_count = 0;
    store_fill  = 0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    cmd_i       = CMD_ADD;
    energy_i    = '0;
    linewidth_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int n = 0; n < DIRECTED_N; n++) begin
      row = directed_rows[n];
      drive_item(row.cmd, row.energy, row.linewidth, 1'b1);
      apply_command(row.cmd, row.energy, row.linewidth, !row.typed);
      if (row.typed && row.typed_count != 0) begin
        h.energy    = row.want_energy;
        h.linewidth = row.want_linewidth;
        h.last      = 1'b1;
        expect_entry(h);
      end
    end
    wait_drained();

    for (int n = 0; n < RANDOM_N; n++) begin
      cmd = ($urandom_range(0, 7) == 0) ? CMD_REPORT : CMD_ADD;
      e   = (cmd == CMD_ADD) ? pick_energy() : $urandom;
      case ($urandom_range(0, 9))
        0: lw = 32'h0000_0000;
        1: lw = 32'hFFFF_FFFF;
        default: lw = $urandom;
      endcase
      // no idling across the middle stretch
      drive_item(cmd, e, lw, !(n >= 80 && n < 160));
      apply_command(cmd, e, lw, 1'b1);
      if (n == 40 || n == 200) wait_drained();
    end

    wait_drained();
    repeat (KEEP_COUNT + 4) @(posedge clk_i);
    if (pending_entries.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_entries.size()));
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
